[hdl/capseq_pkg.sv]
// Shared types, codes and sizes of the capture readiness sequencer.
`default_nettype none

package capseq_pkg;

  localparam int unsigned VALUE_BITS    = 24;
  localparam int unsigned FILTER_BITS   = 8;
  localparam int unsigned OPCODE_BITS   = 3;
  localparam int unsigned KIND_BITS     = 3;
  localparam int unsigned NUM_FLAGS     = 4;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned REG_IDX_BITS  = 3;
  localparam int unsigned NUM_SLOTS     = 10;
  localparam int unsigned SLOT_BITS     = $clog2(NUM_SLOTS);

  // Input opcodes.
  localparam logic [OPCODE_BITS-1:0] OP_PREPARE = 3'd0;
  localparam logic [OPCODE_BITS-1:0] OP_FILTER  = 3'd1;
  localparam logic [OPCODE_BITS-1:0] OP_TEMP    = 3'd2;
  localparam logic [OPCODE_BITS-1:0] OP_ROT     = 3'd3;
  localparam logic [OPCODE_BITS-1:0] OP_DRIFT   = 3'd4;
  localparam logic [OPCODE_BITS-1:0] OP_IDLE    = 3'd5;

  // Result kinds.
  localparam logic [KIND_BITS-1:0] KIND_BATCH    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_SET_TEMP = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_STATE    = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_READ     = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_ROTATE   = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_DONE     = 3'd5;

  // Action codes carried in the argument of state and read results.
  localparam logic [VALUE_BITS-1:0] ACT_TEMP  = VALUE_BITS'(0);
  localparam logic [VALUE_BITS-1:0] ACT_DRIFT = VALUE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] ACT_ROT   = VALUE_BITS'(2);

  // Register indexes.
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_TEMP   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_TEMP_DIFF = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_ROT    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ROT_THRESHOLD = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_RAW_ROT_ANGLE = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_DRIFT  = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_FILTER = 3'd6;

  // Most negative value: no rotator target set.
  localparam logic [VALUE_BITS-1:0] NO_ROTATION = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [OPCODE_BITS-1:0]       opcode;
    logic                         is_light;
    logic                         enforce_temp;
    logic                         enforce_drift;
    logic                         preview;
    logic signed [VALUE_BITS-1:0] reading;
  } in_item_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]         kind;
    logic signed [VALUE_BITS-1:0] argument;
    logic                         last;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] target_temp;
    logic [VALUE_BITS-2:0]        max_temp_diff;
    logic signed [VALUE_BITS-1:0] target_rotation;
    logic [VALUE_BITS-2:0]        rotator_threshold;
    logic signed [VALUE_BITS-1:0] raw_rotator_angle;
    logic [VALUE_BITS-2:0]        target_drift;
    logic [FILTER_BITS-1:0]       target_filter;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic                 eval;
    logic                 emit;
    logic [SLOT_BITS-1:0] slot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mask_any;
    logic slot_hit;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/capture_readiness_sequencer_top.sv]
// A request is evaluated in the cycle after it is accepted; its results then go to
// the output register one slot at a time.
// The controller walks up to ten result slots, one per cycle unless a full slot waits
// for the output register, and takes the next request only once every result is loaded.
// Reset is asynchronous and active low: configuration returns to its defaults, all
// readiness flags are set, nothing is initialised and no completion is pending.
`default_nettype none

module capture_readiness_sequencer_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire capseq_pkg::in_item_t                in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output capseq_pkg::out_item_t                    out_data_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [capseq_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [capseq_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [capseq_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                     pready
);

  capseq_pkg::cfg_t        cfg;
  capseq_pkg::ctrl_cmd_t   cmd;
  capseq_pkg::dp_status_t  status;

  capseq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  capseq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  capseq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/capseq_regs.sv]
// APB configuration registers of the capture readiness sequencer.
`default_nettype none

module capseq_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [capseq_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [capseq_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [capseq_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                     pready,
  output capseq_pkg::cfg_t                         cfg_o
);

  localparam int unsigned V = capseq_pkg::VALUE_BITS;

  capseq_pkg::cfg_t                      cfg_q;
  logic [capseq_pkg::REG_IDX_BITS-1:0]   reg_idx;
  logic                                  wr_en;

  assign reg_idx = paddr[capseq_pkg::REG_IDX_BITS+1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp       <= '0;
      cfg_q.max_temp_diff     <= (V-1)'(16);
      cfg_q.target_rotation   <= capseq_pkg::NO_ROTATION;
      cfg_q.rotator_threshold <= (V-1)'(16);
      cfg_q.raw_rotator_angle <= '0;
      cfg_q.target_drift      <= (V-1)'(32);
      cfg_q.target_filter     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        capseq_pkg::REG_TARGET_TEMP:   cfg_q.target_temp       <= pwdata[V-1:0];
        capseq_pkg::REG_MAX_TEMP_DIFF: cfg_q.max_temp_diff     <= pwdata[V-2:0];
        capseq_pkg::REG_TARGET_ROT:    cfg_q.target_rotation   <= pwdata[V-1:0];
        capseq_pkg::REG_ROT_THRESHOLD: cfg_q.rotator_threshold <= pwdata[V-2:0];
        capseq_pkg::REG_RAW_ROT_ANGLE: cfg_q.raw_rotator_angle <= pwdata[V-1:0];
        capseq_pkg::REG_TARGET_DRIFT:  cfg_q.target_drift      <= pwdata[V-2:0];
        capseq_pkg::REG_TARGET_FILTER:
          cfg_q.target_filter <= pwdata[capseq_pkg::FILTER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      capseq_pkg::REG_TARGET_TEMP:
        prdata = capseq_pkg::APB_DATA_BITS'(cfg_q.target_temp);
      capseq_pkg::REG_MAX_TEMP_DIFF:
        prdata = capseq_pkg::APB_DATA_BITS'(cfg_q.max_temp_diff);
      capseq_pkg::REG_TARGET_ROT:
        prdata = capseq_pkg::APB_DATA_BITS'(cfg_q.target_rotation);
      capseq_pkg::REG_ROT_THRESHOLD:
        prdata = capseq_pkg::APB_DATA_BITS'(cfg_q.rotator_threshold);
      capseq_pkg::REG_RAW_ROT_ANGLE:
        prdata = capseq_pkg::APB_DATA_BITS'(cfg_q.raw_rotator_angle);
      capseq_pkg::REG_TARGET_DRIFT:
        prdata = capseq_pkg::APB_DATA_BITS'(cfg_q.target_drift);
      capseq_pkg::REG_TARGET_FILTER:
        prdata = capseq_pkg::APB_DATA_BITS'(cfg_q.target_filter);
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/capseq_ctrl.sv]
// Controller state machine: takes a request, has it evaluated, then walks the result slots.
`default_nettype none

module capseq_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire capseq_pkg::dp_status_t status_i,
  output capseq_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_e;

  state_e                             state_q;
  logic [capseq_pkg::SLOT_BITS-1:0]   slot_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.eval = (state_q == ST_EVAL);
    cmd_o.emit = (state_q == ST_EMIT) && status_i.mask_any && status_i.slot_hit &&
                 status_i.out_free;
    cmd_o.slot = slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          state_q <= ST_EMIT;
          slot_q  <= '0;
        end
        ST_EMIT: begin
          if (!status_i.mask_any) begin
            state_q <= ST_IDLE;
          end else if (!status_i.slot_hit || status_i.out_free) begin
            // Empty slots are skipped; a full one waits for the output register.
            slot_q <= slot_q + capseq_pkg::SLOT_BITS'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/capseq_dp.sv]
// Datapath: readiness state, threshold checks, result slot mask and output register.
`default_nettype none

module capseq_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire capseq_pkg::cfg_t       cfg_i,
  input  wire capseq_pkg::in_item_t   in_data_i,
  input  wire capseq_pkg::ctrl_cmd_t  cmd_i,
  output capseq_pkg::dp_status_t      status_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output capseq_pkg::out_item_t       out_data_o
);

  localparam int unsigned V = capseq_pkg::VALUE_BITS;
  localparam int unsigned N = capseq_pkg::NUM_SLOTS;

  // Readiness and initialised flag bits.
  localparam int unsigned F_FILTER = 0;
  localparam int unsigned F_TEMP   = 1;
  localparam int unsigned F_ROT    = 2;
  localparam int unsigned F_DRIFT  = 3;

  // Job flag bits.
  localparam int unsigned J_LIGHT  = 0;
  localparam int unsigned J_TEMP   = 1;
  localparam int unsigned J_DRIFT  = 2;

  // Result slots in the order they leave the block.
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_BATCH      = 4'd0;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_SET_TEMP   = 4'd1;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_TEMP_STATE = 4'd2;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_TEMP_READ  = 4'd3;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_DRFT_STATE = 4'd4;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_DRFT_READ  = 4'd5;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_ROT_STATE  = 4'd6;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_ROTATE     = 4'd7;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_ROT_READ   = 4'd8;
  localparam logic [capseq_pkg::SLOT_BITS-1:0] SLOT_DONE       = 4'd9;

  function automatic logic [V:0] abs_diff(input logic [V-1:0] a, input logic [V-1:0] b);
    logic [V:0] d;
    d = {a[V-1], a} - {b[V-1], b};
    return d[V] ? (~d + (V+1)'(1)) : d;
  endfunction

  capseq_pkg::in_item_t                 item_q;
  capseq_pkg::out_item_t                out_q;
  logic                                 out_valid_q;
  logic                                 busy_q, busy_d;
  logic                                 pending_q, pending_d;
  logic [capseq_pkg::NUM_FLAGS-1:0]     ready_q, ready_d;
  logic [capseq_pkg::NUM_FLAGS-1:0]     init_q, init_d;
  logic [2:0]                           jf_q, jf_d;
  logic [V-1:0]                         temp_now_q, temp_now_d;
  logic [V-1:0]                         rot_now_q, rot_now_d;
  logic [V-1:0]                         drift_now_q, drift_now_d;
  logic [N-1:0]                         mask_q, mask_d;

  logic [V-1:0]                         rd;
  logic [V-1:0]                         temp_sel, rot_sel, drift_sel;
  logic                                 temp_out, rot_out, drift_ok;
  logic                                 chk;
  logic                                 out_free;
  logic                                 slot_ok;
  logic [N-1:0]                         slot_bit;
  logic [capseq_pkg::KIND_BITS-1:0]     slot_kind;
  logic [V-1:0]                         slot_arg;

  assign rd = item_q.reading;

  // A report checks its new reading, a prepare the stored one.
  assign temp_sel  = (item_q.opcode == capseq_pkg::OP_TEMP)  ? rd : temp_now_q;
  assign rot_sel   = (item_q.opcode == capseq_pkg::OP_ROT)   ? rd : rot_now_q;
  assign drift_sel = (item_q.opcode == capseq_pkg::OP_DRIFT) ? rd : drift_now_q;

  assign temp_out = abs_diff(cfg_i.target_temp, temp_sel) > {2'b00, cfg_i.max_temp_diff};
  assign rot_out  = abs_diff(rot_sel, cfg_i.target_rotation) >
                    {2'b00, cfg_i.rotator_threshold};
  assign drift_ok = drift_sel[V-1] || (drift_sel[V-2:0] <= cfg_i.target_drift);

  always_comb begin
    busy_d      = busy_q;
    pending_d   = pending_q;
    ready_d     = ready_q;
    init_d      = init_q;
    jf_d        = jf_q;
    temp_now_d  = temp_now_q;
    rot_now_d   = rot_now_q;
    drift_now_d = drift_now_q;
    mask_d      = '0;
    chk         = 1'b0;
    unique case (item_q.opcode)
      capseq_pkg::OP_PREPARE: begin
        // A repeated prepare with unchanged enforce flags is dropped while busy.
        if (!(busy_q && item_q.enforce_temp == jf_q[J_TEMP] &&
              item_q.enforce_drift == jf_q[J_DRIFT])) begin
          busy_d = 1'b1;
          jf_d   = {item_q.enforce_drift, item_q.enforce_temp, item_q.is_light};
          ready_d = '1;
          mask_d[SLOT_BATCH] = 1'b1;
          if (item_q.enforce_temp && (temp_out || !init_q[F_TEMP])) begin
            ready_d[F_TEMP]         = 1'b0;
            mask_d[SLOT_SET_TEMP]   = 1'b1;
            mask_d[SLOT_TEMP_STATE] = 1'b1;
            mask_d[SLOT_TEMP_READ]  = !init_q[F_TEMP];
          end
          if (item_q.enforce_drift && item_q.is_light &&
              !(drift_ok && init_q[F_DRIFT])) begin
            ready_d[F_DRIFT]        = 1'b0;
            mask_d[SLOT_DRFT_STATE] = 1'b1;
            mask_d[SLOT_DRFT_READ]  = !init_q[F_DRIFT];
          end
          if (cfg_i.target_rotation != capseq_pkg::NO_ROTATION &&
              (rot_out || !init_q[F_ROT])) begin
            ready_d[F_ROT]         = 1'b0;
            mask_d[SLOT_ROT_STATE] = 1'b1;
            mask_d[SLOT_ROTATE]    = 1'b1;
            mask_d[SLOT_ROT_READ]  = !init_q[F_ROT];
          end
          pending_d = 1'b0;
          chk       = 1'b1;
        end
      end
      capseq_pkg::OP_FILTER: begin
        init_d[F_FILTER] = 1'b1;
        if (rd == V'(cfg_i.target_filter)) ready_d[F_FILTER] = 1'b1;
        chk = 1'b1;
      end
      capseq_pkg::OP_TEMP: begin
        temp_now_d     = rd;
        init_d[F_TEMP] = 1'b1;
        if (!jf_q[J_TEMP] || !temp_out) ready_d[F_TEMP] = 1'b1;
        chk = 1'b1;
      end
      capseq_pkg::OP_ROT: begin
        rot_now_d     = rd;
        init_d[F_ROT] = 1'b1;
        if (!rot_out) ready_d[F_ROT] = 1'b1;
        chk = 1'b1;
      end
      capseq_pkg::OP_DRIFT: begin
        drift_now_d      = rd;
        init_d[F_DRIFT]  = 1'b1;
        ready_d[F_DRIFT] = !jf_q[J_DRIFT] || !jf_q[J_LIGHT] || drift_ok;
        chk = 1'b1;
      end
      capseq_pkg::OP_IDLE: busy_d = 1'b0;
      default: ;
    endcase
    // Completion fires once per prepare, when all four flags are up.
    if (chk && !pending_d && (&ready_d)) begin
      pending_d         = 1'b1;
      mask_d[SLOT_DONE] = 1'b1;
    end
  end

  always_comb begin
    unique case (cmd_i.slot)
      SLOT_BATCH:      begin slot_kind = capseq_pkg::KIND_BATCH;
                             slot_arg  = V'(!item_q.preview); end
      SLOT_SET_TEMP:   begin slot_kind = capseq_pkg::KIND_SET_TEMP;
                             slot_arg  = cfg_i.target_temp; end
      SLOT_TEMP_STATE: begin slot_kind = capseq_pkg::KIND_STATE;
                             slot_arg  = capseq_pkg::ACT_TEMP; end
      SLOT_TEMP_READ:  begin slot_kind = capseq_pkg::KIND_READ;
                             slot_arg  = capseq_pkg::ACT_TEMP; end
      SLOT_DRFT_STATE: begin slot_kind = capseq_pkg::KIND_STATE;
                             slot_arg  = capseq_pkg::ACT_DRIFT; end
      SLOT_DRFT_READ:  begin slot_kind = capseq_pkg::KIND_READ;
                             slot_arg  = capseq_pkg::ACT_DRIFT; end
      SLOT_ROT_STATE:  begin slot_kind = capseq_pkg::KIND_STATE;
                             slot_arg  = capseq_pkg::ACT_ROT; end
      SLOT_ROTATE:     begin slot_kind = capseq_pkg::KIND_ROTATE;
                             slot_arg  = cfg_i.raw_rotator_angle; end
      SLOT_ROT_READ:   begin slot_kind = capseq_pkg::KIND_READ;
                             slot_arg  = capseq_pkg::ACT_ROT; end
      SLOT_DONE:       begin slot_kind = capseq_pkg::KIND_DONE;
                             slot_arg  = '0; end
      default:         begin slot_kind = capseq_pkg::KIND_DONE;
                             slot_arg  = '0; end
    endcase
  end

  assign slot_ok  = (cmd_i.slot < capseq_pkg::SLOT_BITS'(N));
  assign slot_bit = slot_ok ? (N'(1) << cmd_i.slot) : '0;
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.mask_any = |mask_q;
  assign status_o.slot_hit = |(mask_q & slot_bit);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.emit) begin
      out_q.kind     <= slot_kind;
      out_q.argument <= slot_arg;
      out_q.last     <= ((mask_q & ~slot_bit) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pending_q   <= 1'b1;
      ready_q     <= '1;
      init_q      <= '0;
      jf_q        <= '0;
      temp_now_q  <= '0;
      rot_now_q   <= '0;
      drift_now_q <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        busy_q      <= busy_d;
        pending_q   <= pending_d;
        ready_q     <= ready_d;
        init_q      <= init_d;
        jf_q        <= jf_d;
        temp_now_q  <= temp_now_d;
        rot_now_q   <= rot_now_d;
        drift_now_q <= drift_now_d;
        mask_q      <= mask_d;
      end else if (cmd_i.emit) begin
        mask_q <= mask_q & ~slot_bit;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over one still waiting");

  a_emit_hits_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> |(mask_q & slot_bit))
    else $error("result loaded from an empty slot");

  a_eval_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval |-> (mask_q == '0))
    else $error("new request evaluated with results still queued");

  a_done_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q[SLOT_DONE] |-> (pending_q && (&ready_q)))
    else $error("completion queued without all flags ready");

endmodule

`default_nettype wire
